// ===== design/dbwc_pkg.sv =====
// Types and constants shared by the delay-based window controller.
`default_nettype none
package dbwc_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_UP_THRESH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DELTA    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_DELTA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_DELTA  = 3'd4;

    localparam logic signed [31:0] WIN_RESET  = 32'sd4096;
    localparam logic signed [31:0] WIN_MIN    = 32'sd512;
    localparam logic signed [31:0] WIN_MAX    = 32'sd2560000;
    localparam logic [16:0]        DELAY_INIT = 17'd99999;
    localparam logic [10:0]        LOST_MAX   = 11'd2047;

    typedef enum logic [0:0] {
        OP_SEND = 1'b0,
        OP_ACK  = 1'b1
    } op_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] seq_num;
        logic [31:0] send_time;
        logic [31:0] recv_time;
        logic [31:0] ack_arrival_time;
    } in_beat_t;

    typedef struct packed {
        logic [13:0] window_datagrams;
        logic [10:0] lost_count;
        logic        ring_full;
        logic [16:0] min_rtt;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND,
        ST_DROP_RD,
        ST_DROP_CHK,
        ST_LATE_CHK,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_DROP2_RD,
        ST_DROP2_CHK,
        ST_DELAY,
        ST_ADJUST,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic do_send;
        logic rd_head;
        logic rd_srch;
        logic pop_head;
        logic pop_lost;
        logic srch_start;
        logic srch_step;
        logic srch_clear;
        logic do_delay;
        logic do_adjust;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_ack;
        logic ring_empty;
        logic head_valid;
        logic head_late;
        logic srch_done;
        logic srch_valid;
        logic srch_eq;
        logic srch_gt;
    } status_t;

endpackage
`default_nettype wire

// ===== design/dbwc_ctrl.sv =====
// Sequencer for one send or ack beat of the window controller.
`default_nettype none
module dbwc_ctrl
    import dbwc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire status_t stat,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SEND;
            ST_SEND:      state_next = stat.op_ack ? ST_DROP_RD : ST_OUT;
            ST_DROP_RD:   state_next = stat.ring_empty ? ST_SRCH_RD : ST_DROP_CHK;
            ST_DROP_CHK:  state_next = stat.head_valid ? ST_LATE_CHK : ST_DROP_RD;
            ST_LATE_CHK:  state_next = stat.head_late ? ST_DROP_RD : ST_SRCH_RD;
            ST_SRCH_RD:   state_next = stat.srch_done ? ST_DROP2_RD : ST_SRCH_CHK;
            ST_SRCH_CHK: begin
                if (stat.srch_valid && (stat.srch_eq || stat.srch_gt))
                    state_next = ST_DROP2_RD;
                else
                    state_next = ST_SRCH_RD;
            end
            ST_DROP2_RD:  state_next = stat.ring_empty ? ST_DELAY : ST_DROP2_CHK;
            ST_DROP2_CHK: state_next = stat.head_valid ? ST_DELAY : ST_DROP2_RD;
            ST_DELAY:     state_next = ST_ADJUST;
            ST_ADJUST:    state_next = ST_OUT;
            ST_OUT:       if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
            end
            ST_SEND: begin
                cmd.do_send    = !stat.op_ack;
                cmd.srch_start = 1'b1;
            end
            ST_DROP_RD:  cmd.rd_head = !stat.ring_empty;
            ST_DROP_CHK: cmd.pop_head = !stat.head_valid;
            ST_LATE_CHK: begin
                cmd.pop_head = stat.head_late;
                cmd.pop_lost = stat.head_late;
            end
            ST_SRCH_RD:  cmd.rd_srch = !stat.srch_done;
            ST_SRCH_CHK: begin
                cmd.srch_step  = 1'b1;
                cmd.srch_clear = stat.srch_valid && stat.srch_eq;
            end
            ST_DROP2_RD:  cmd.rd_head = !stat.ring_empty;
            ST_DROP2_CHK: cmd.pop_head = !stat.head_valid;
            ST_DELAY:     cmd.do_delay = 1'b1;
            ST_ADJUST:    cmd.do_adjust = 1'b1;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/dbwc_dpath.sv =====
// Ring of outstanding datagrams, delay trackers and window arithmetic.
`default_nettype none
module dbwc_dpath
    import dbwc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 1024,
    parameter int unsigned REORDER_MS = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire in_beat_t         s_data,
    input  wire cmd_t             cmd,
    output status_t               stat,
    output out_beat_t             m_data
);

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    logic [CFG_W-1:0] up_th_reg, up_d_reg, dn_th_reg, dn_d_reg, loss_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_th_reg  <= 16'd16;
            up_d_reg   <= 16'd256;
            dn_th_reg  <= 16'd160;
            dn_d_reg   <= 16'd256;
            loss_d_reg <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_UP_THRESH:   up_th_reg  <= cfg_data;
                CFG_UP_DELTA:    up_d_reg   <= cfg_data;
                CFG_DOWN_THRESH: dn_th_reg  <= cfg_data;
                CFG_DOWN_DELTA:  dn_d_reg   <= cfg_data;
                CFG_LOSS_DELTA:  loss_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    in_beat_t in_reg;
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) in_reg <= s_data;
    end

    // seq and time stores, plus a valid bit store cleared by a sweep after reset
    logic [63:0] rec_mem [RING_DEPTH];
    logic        vld_mem [RING_DEPTH];
    logic [63:0] rd_rec_reg;
    logic        rd_vld_reg;

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] k_reg;
    logic [AW-1:0] srch_slot_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [AW-1:0] tail_slot, srch_slot, rd_addr;
    logic [AW:0]   tail_sum, srch_sum;
    assign tail_sum  = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign srch_sum  = {1'b0, head_reg} + (AW+1)'(k_reg);
    assign tail_slot = (tail_sum >= (AW+1)'(RING_DEPTH)) ?
                       AW'(tail_sum - (AW+1)'(RING_DEPTH)) : AW'(tail_sum);
    assign srch_slot = (srch_sum >= (AW+1)'(RING_DEPTH)) ?
                       AW'(srch_sum - (AW+1)'(RING_DEPTH)) : AW'(srch_sum);
    assign rd_addr   = cmd.rd_srch ? srch_slot : head_reg;

    logic send_ok;
    assign send_ok = cmd.do_send && (count_reg < DEPTH_C);

    logic          vld_we;
    logic [AW-1:0] vld_waddr;
    logic          vld_wdata;
    always_comb begin
        vld_we    = 1'b0;
        vld_waddr = head_reg;
        vld_wdata = 1'b0;
        if (clr_busy_reg) begin
            vld_we    = 1'b1;
            vld_waddr = clr_addr_reg;
        end else if (send_ok) begin
            vld_we    = 1'b1;
            vld_waddr = tail_slot;
            vld_wdata = 1'b1;
        end else if (cmd.pop_head) begin
            vld_we = 1'b1;
        end else if (cmd.srch_clear) begin
            vld_we    = 1'b1;
            vld_waddr = srch_slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (send_ok) rec_mem[tail_slot] <= {in_reg.seq_num, in_reg.send_time};
        if (cmd.rd_head || cmd.rd_srch) rd_rec_reg <= rec_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (vld_we) vld_mem[vld_waddr] <= vld_wdata;
        if (cmd.rd_head || cmd.rd_srch) rd_vld_reg <= vld_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(RING_DEPTH - 1)) clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (send_ok) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.pop_head) begin
            head_reg  <= (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.srch_start) begin
            k_reg <= '0;
        end else if (cmd.pop_head) begin
            k_reg <= '0;
        end else if (cmd.rd_srch) begin
            srch_slot_reg <= srch_slot;
        end else if (cmd.srch_step) begin
            k_reg <= k_reg + 1'b1;
        end
    end

    logic [31:0] late_d;
    assign late_d = in_reg.send_time - rd_rec_reg[31:0];

    assign stat.op_ack     = in_reg.operation;
    assign stat.ring_empty = (count_reg == '0);
    assign stat.head_valid = rd_vld_reg;
    assign stat.head_late  = !late_d[31] && (late_d > 32'(REORDER_MS));
    assign stat.srch_done  = (k_reg >= count_reg);
    assign stat.srch_valid = rd_vld_reg;
    assign stat.srch_eq    = (rd_rec_reg[63:32] == in_reg.seq_num);
    assign stat.srch_gt    = (rd_rec_reg[63:32] > in_reg.seq_num);

    // window and delay state
    logic signed [31:0] win_reg, wacc_reg;
    logic [10:0]        lost_reg;
    logic signed [32:0] min_skew_reg, skew_reg;
    logic [16:0]        min_rtt_reg;
    logic [31:0]        rtt;
    logic signed [32:0] skew;
    logic signed [32:0] new_min;
    logic signed [33:0] excess_d;
    logic               up_hit, dn_hit;
    logic signed [33:0] wsum;

    assign skew    = $signed({1'b0, in_reg.recv_time}) - $signed({1'b0, in_reg.send_time});
    assign rtt     = in_reg.ack_arrival_time - in_reg.send_time;

    // excess*16 <= th  <=>  excess <= th>>4 ; the down test compares excess*16 >= th directly
    assign excess_d = 34'(skew_reg) - 34'(min_skew_reg);
    assign up_hit   = excess_d <= $signed({22'd0, up_th_reg[15:4]});
    assign dn_hit   = ({excess_d, 4'd0} >= $signed({22'd0, dn_th_reg}));
    assign new_min  = (skew < min_skew_reg) ? skew : min_skew_reg;

    always_comb begin
        wsum = 34'(wacc_reg);
        if (up_hit) wsum = wsum + $signed({18'd0, up_d_reg});
        if (dn_hit) wsum = wsum - $signed({18'd0, dn_d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= WIN_RESET;
            min_skew_reg <= 33'sd99999;
            min_rtt_reg  <= DELAY_INIT;
        end else begin
            if (cmd.do_delay) begin
                min_skew_reg <= new_min;
                if (rtt < {15'd0, min_rtt_reg}) min_rtt_reg <= rtt[16:0];
            end
            if (cmd.do_adjust) begin
                if (wsum < 34'(WIN_MIN))      win_reg <= WIN_MIN;
                else if (wsum > 34'(WIN_MAX)) win_reg <= WIN_MAX;
                else                          win_reg <= 32'(wsum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.srch_start) begin
            wacc_reg <= win_reg;
            lost_reg <= '0;
        end else if (cmd.pop_lost) begin
            wacc_reg <= wacc_reg - $signed({16'd0, loss_d_reg});
            if (lost_reg != LOST_MAX) lost_reg <= lost_reg + 1'b1;
        end
        if (cmd.do_delay) skew_reg <= skew;
    end

    // remembers whether this send was accepted
    logic send_ok_d;
    always_ff @(posedge aclk) begin
        if (cmd.srch_start) send_ok_d <= !in_reg.operation && (count_reg < DEPTH_C);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data.window_datagrams <= win_reg[21:8];
            m_data.lost_count       <= stat.op_ack ? lost_reg : 11'd0;
            m_data.ring_full        <= !stat.op_ack && (count_reg == DEPTH_C) && !send_ok_d;
            m_data.min_rtt          <= min_rtt_reg;
        end
    end

endmodule
`default_nettype wire

// ===== design/delay_based_window_controller.sv =====
// Top level of the delay-based congestion window controller.
//  port group  dir  meaning
//  s_*         in   send or ack event beat
//  m_*         out  window result beat, one per input beat
//  cfg_*       in   register writes, no wait
// A send passes through the SEND and OUT states; an ack also drops stale
// entries, checks the head for lateness and searches the ring one entry at a
// time, through the single read port of the ring memory.
// After reset the ring valid store is swept over all RING_DEPTH entries; beats
// stall until the sweep finishes. A result waits in its register while
// m_ready is low.
`default_nettype none
module delay_based_window_controller
    import dbwc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 1024,
    parameter int unsigned REORDER_MS = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_beat_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_beat_t             m_data
);

    cmd_t    cmd;
    status_t stat;
    logic    ready_raw;
    logic    sweep_reg;
    logic [$clog2(RING_DEPTH)-1:0] sweep_cnt_reg;

    // mirrors the datapath valid-store sweep to hold off input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end else if (sweep_reg) begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == ($clog2(RING_DEPTH))'(RING_DEPTH - 1)) sweep_reg <= 1'b0;
        end
    end

    assign s_ready = ready_raw && !sweep_reg;

    dbwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid && !sweep_reg),
        .s_ready (ready_raw),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dbwc_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .REORDER_MS (REORDER_MS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
